[sv/ssjf_pkg.sv]
package ssjf_pkg;

  localparam int unsigned ElemW  = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned LenW   = 12;
  localparam int unsigned SimW   = 20;
  localparam int unsigned ShareW = 12;
  localparam int unsigned UnionW = 13;
  localparam int unsigned SimScale = 1000000;

  // A completed pair handed from the load side to the merge side.
  typedef struct packed {
    logic [TagW-1:0] row_tag;
    logic [TagW-1:0] col_tag;
  } job_t;

  typedef struct packed {
    logic [TagW-1:0]   row_id;
    logic [TagW-1:0]   col_id;
    logic              passed;
    logic [SimW-1:0]   similarity;
    logic [ShareW-1:0] shared_count;
    logic [UnionW-1:0] union_size;
  } result_t;

endpackage

[sv/ssjf_front.sv]
module ssjf_front #(
  parameter int unsigned MaxLength = 2048,
  parameter int unsigned AddrW     = 11,
  parameter int unsigned CntW      = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ssjf_pkg::LenW-1:0] vector_length_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ssjf_pkg::job_t          in_job_i,
  input  logic                    busy_i,
  output logic                    wr_en_o,
  output logic [AddrW-1:0]        wr_addr_o,
  output logic [CntW-1:0]         len_o,
  output logic                    job_valid_o,
  output ssjf_pkg::job_t          job_o
);
  import ssjf_pkg::*;

  logic [CntW-1:0] load_count_q, load_count_d;
  logic [CntW-1:0] len;
  logic [CntW-1:0] idx;
  logic            last;

  // Effective length, clamped to one through MaxLength.
  always_comb begin
    if (vector_length_i == '0) begin
      len = CntW'(1);
    end else if (CntW'(vector_length_i) > CntW'(MaxLength)) begin
      len = CntW'(MaxLength);
    end else begin
      len = CntW'(vector_length_i);
    end
  end

  assign idx        = (load_count_q >= len) ? len - CntW'(1) : load_count_q;
  assign last       = (idx + CntW'(1)) >= len;
  // The store may only be written while the merge side is not reading it.
  assign in_ready_o = !busy_i;
  assign wr_en_o    = in_valid_i && in_ready_o;
  assign wr_addr_o  = idx[AddrW-1:0];
  assign len_o      = len;
  assign job_valid_o = wr_en_o && last;
  assign job_o      = in_job_i;

  always_comb begin
    load_count_d = load_count_q;
    if (wr_en_o) begin
      load_count_d = last ? '0 : idx + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else begin
      load_count_q <= load_count_d;
    end
  end

endmodule

[sv/ssjf_divider.sv]
module ssjf_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssjf_pkg::ShareW-1:0] shared_i,
  input  logic [ssjf_pkg::UnionW-1:0] union_i,
  output logic                        done_o,
  output logic [ssjf_pkg::SimW-1:0]   quot_o
);
  import ssjf_pkg::*;

  localparam int unsigned NumW = ShareW + SimW;
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]   num_q, num_d;
  logic [UnionW:0]   rem_q, rem_d;
  logic [UnionW-1:0] den_q;
  logic [StepW-1:0]  step_q, step_d;
  logic              run_q, run_d;
  logic              run_past_q;
  logic [UnionW+1:0] trial;

  assign trial  = {rem_q, num_q[NumW-1]} - {2'b00, den_q};
  assign quot_o = num_q[SimW-1:0];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    run_d  = run_q;
    if (start_i) begin
      num_d  = NumW'(shared_i) * NumW'(SimScale);
      rem_d  = '0;
      step_d = StepW'(NumW);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (trial[UnionW+1]) begin
        rem_d = {rem_q[UnionW-1:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end else begin
        rem_d = trial[UnionW:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      step_q     <= '0;
      run_past_q <= 1'b0;
    end else begin
      run_q      <= run_d;
      step_q     <= step_d;
      run_past_q <= run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= union_i;
    end
  end

  // The quotient is complete in the cycle after the last step.
  assign done_o = run_past_q && !run_q;

endmodule

[sv/ssjf_back.sv]
module ssjf_back #(
  parameter int unsigned MaxLength = 2048,
  parameter int unsigned AddrW     = 11,
  parameter int unsigned CntW      = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  input  logic [ssjf_pkg::ElemW-1:0]    wr_a_i,
  input  logic [ssjf_pkg::ElemW-1:0]    wr_b_i,
  input  logic [CntW-1:0]               len_i,
  input  logic                          job_valid_i,
  input  ssjf_pkg::job_t                job_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ssjf_pkg::result_t             res_o
);
  import ssjf_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [ElemW-1:0] mem_a [MaxLength];
  logic [ElemW-1:0] mem_b [MaxLength];
  logic [ElemW-1:0] va_q, vb_q;

  logic [2:0]        st_q, st_d;
  logic [CntW-1:0]   pa_q, pa_d, pb_q, pb_d, len_q;
  logic [ShareW-1:0] match_q, match_d;
  logic [UnionW-1:0] union_q, union_d;
  job_t              job_q;
  result_t           res_q;
  logic              res_valid_q;

  // Long division of the scaled match count by the union, run by the divider.
  logic              div_start, div_done;
  logic [SimW-1:0]   div_quot;

  logic a_in, b_in, a_nz, b_nz, a_gt;

  ssjf_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .shared_i(match_q), .union_i(union_q),
    .done_o(div_done), .quot_o(div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
    va_q <= mem_a[pa_d[AddrW-1:0]];
    vb_q <= mem_b[pb_d[AddrW-1:0]];
  end

  assign a_in  = pa_q < len_q;
  assign b_in  = pb_q < len_q;
  assign a_nz  = va_q != '0;
  assign b_nz  = vb_q != '0;
  assign a_gt  = $signed(va_q) > $signed(vb_q);

  always_comb begin
    st_d      = st_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    match_d   = match_q;
    union_d   = union_q;
    div_start = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          pa_d    = '0;
          pb_d    = '0;
          match_d = '0;
          union_d = '0;
          st_d    = StRead;
        end
      end
      StRead: st_d = StCmp;
      StCmp: begin
        if (a_in && b_in) begin
          if (!a_nz && !b_nz) begin
            pa_d = pa_q + CntW'(1);
            pb_d = pb_q + CntW'(1);
          end else if (va_q == vb_q) begin
            match_d = match_q + ShareW'(1);
            union_d = union_q + UnionW'(1);
            pa_d    = pa_q + CntW'(1);
            pb_d    = pb_q + CntW'(1);
          end else if (!a_nz || (b_nz && a_gt)) begin
            union_d = union_q + UnionW'(1);
            pb_d    = pb_q + CntW'(1);
          end else begin
            union_d = union_q + UnionW'(1);
            pa_d    = pa_q + CntW'(1);
          end
          st_d = StRead;
        end else if (a_in) begin
          if (a_nz) union_d = union_q + UnionW'(1);
          pa_d = pa_q + CntW'(1);
          st_d = StRead;
        end else if (b_in) begin
          if (b_nz) union_d = union_q + UnionW'(1);
          pb_d = pb_q + CntW'(1);
          st_d = StRead;
        end else if (union_q == '0) begin
          st_d = StOut;
        end else begin
          div_start = 1'b1;
          st_d      = StDiv;
        end
      end
      StDiv: begin
        if (div_done) st_d = StOut;
      end
      StOut: begin
        if (!res_valid_q || res_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StOut && (!res_valid_q || res_ready_i)) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    match_q <= match_d;
    union_q <= union_d;
    if (st_q == StIdle && job_valid_i) begin
      job_q <= job_i;
      len_q <= len_i;
    end
    if (st_q == StOut && (!res_valid_q || res_ready_i)) begin
      res_q.row_id       <= job_q.row_tag;
      res_q.col_id       <= job_q.col_tag;
      res_q.passed       <= (union_q != '0) &&
                            ((UnionW + 4)'(match_q) * (UnionW + 4)'(10) >
                             (UnionW + 4)'(union_q));
      res_q.similarity   <= (union_q == '0) ? '0 : div_quot;
      res_q.shared_count <= match_q;
      res_q.union_size   <= union_q;
    end
  end

  // The store is locked from the completing write until the result is queued.
  assign busy_o      = st_q != StIdle;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_job_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> st_q == StIdle) else $error("pair completed while merge busy");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> st_q == StIdle) else $error("store written during merge");
  a_match_le_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> UnionW'(match_q) <= union_q) else $error("match exceeds union");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |=> res_valid_q && $stable(res_q))
    else $error("result dropped while stalled");
`endif

endmodule

[sv/sorted_sketch_jaccard_filter_top.sv]
// Sorted-sketch Jaccard filter. Each input transfer loads one element of
// sketch A and one of sketch B at the next index; the transfer that fills
// index vector_length-1 completes the pair and starts a two-pointer merge
// over the stored vectors (zero marks an empty slot). The merge reads both
// stores once per step; each step passes through a read and a compare state.
// A pair of length len loads one element per cycle while s_axis_tready is
// high, takes up to 2*len merge steps plus a final check, then a bit-serial
// divide that yields floor(shared*1e6/union) (skipped when the union is
// empty), and then its result is queued in the output register.
// While a pair is merging, s_axis_tready is low; a finished result sits in
// an output register, so the next pair can be loaded while it waits. If that
// next pair completes before the waiting result is taken, s_axis_tready stays
// low until m_axis_tready frees the output register.
// vector_length of zero acts as one and values above MAX_LENGTH clamp to it.
// Write vector_length only while the block is idle.
module sorted_sketch_jaccard_filter_top #(
  parameter int unsigned MAX_LENGTH = 2048
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [11:0]  cfg_wdata_i,     // vector_length
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] elem_a, [63:32] elem_b, [79:64] row_tag, [95:80] col_tag
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] row_id, [31:16] col_id, [32] passed, [52:33] similarity,
  // [64:53] shared_count, [77:65] union_size, [79:78] zero
  output logic [79:0]  m_axis_tdata
);
  import ssjf_pkg::*;

  localparam int unsigned AddrW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LENGTH + 1) > LenW ?
                                  $clog2(MAX_LENGTH + 1) : LenW;

  logic [LenW-1:0] vector_length_q;
  logic            wr_en, job_valid, busy;
  logic [AddrW-1:0] wr_addr;
  logic [CntW-1:0] len;
  job_t            in_job, job;
  result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= LenW'(2048);
    end else if (cfg_we_i) begin
      vector_length_q <= cfg_wdata_i;
    end
  end

  assign in_job.row_tag = s_axis_tdata[79:64];
  assign in_job.col_tag = s_axis_tdata[95:80];

  ssjf_front #(.MaxLength(MAX_LENGTH), .AddrW(AddrW), .CntW(CntW)) u_front (
    .clk_i, .rst_ni,
    .vector_length_i(vector_length_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_job_i(in_job), .busy_i(busy),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .len_o(len),
    .job_valid_o(job_valid), .job_o(job)
  );

  ssjf_back #(.MaxLength(MAX_LENGTH), .AddrW(AddrW), .CntW(CntW)) u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr),
    .wr_a_i(s_axis_tdata[31:0]), .wr_b_i(s_axis_tdata[63:32]),
    .len_i(len), .job_valid_i(job_valid), .job_i(job),
    .busy_o(busy),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.union_size, res.shared_count, res.similarity,
                         res.passed, res.col_id, res.row_id};

endmodule

[tb/sorted_sketch_jaccard_filter_top_tb.sv]
`timescale 1ns / 100ps

module sorted_sketch_jaccard_filter_top_tb;
  import ssjf_pkg::*;

  localparam int unsigned MaxLen = 2048;
  localparam int unsigned IdleLimit = 40000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;

  sorted_sketch_jaccard_filter_top #(.MAX_LENGTH(MaxLen)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // Clock: 12 ns period.
  always begin
    clk_i = 1'b0; #6;
    clk_i = 1'b1; #6;
  end

  // Predictor state: the two stored sketches, the load index and the length register.
  logic [ElemW-1:0] sketch_a [MaxLen];
  logic [ElemW-1:0] sketch_b [MaxLen];
  int unsigned      load_idx;
  logic [LenW-1:0]  length_reg;

  result_t expected_results[$];
  int          error_count;
  int unsigned idle_cycles;
  bit          send_gaps;
  bit          recv_gaps;
  int unsigned recv_hold;
  int unsigned recv_burst;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Two-pointer merge over the stored sketches, then the scaled similarity.
  function automatic result_t jaccard_of_pair(input int unsigned len,
                                              input logic [TagW-1:0] row,
                                              input logic [TagW-1:0] col);
    result_t r;
    int unsigned pa, pb, shared, uni;
    logic [ElemW-1:0] va, vb;
    longint unsigned sim;
    pa = 0; pb = 0; shared = 0; uni = 0; sim = 0;
    while (pa < len && pb < len) begin
      va = sketch_a[pa];
      vb = sketch_b[pb];
      if (va == 0 && vb == 0) begin
        pa++; pb++;
      end else if (va == vb) begin
        shared++; uni++; pa++; pb++;
      end else if (va == 0 || (vb != 0 && $signed(va) > $signed(vb))) begin
        uni++; pb++;
      end else begin
        uni++; pa++;
      end
    end
    for (; pa < len; pa++) if (sketch_a[pa] != 0) uni++;
    for (; pb < len; pb++) if (sketch_b[pb] != 0) uni++;
    r.row_id = row;
    r.col_id = col;
    r.passed = 1'b0;
    if (uni > 0) begin
      sim = (longint'(shared) * SimScale) / uni;
      r.passed = (shared * 10 > uni);
    end
    r.similarity   = sim[SimW-1:0];
    r.shared_count = shared[ShareW-1:0];
    r.union_size   = uni[UnionW-1:0];
    return r;
  endfunction

  function automatic void predict_load(input logic [95:0] item);
    int unsigned len, idx;
    len = (length_reg == 0) ? 1 : ((length_reg > MaxLen) ? MaxLen : length_reg);
    idx = (load_idx >= len) ? len - 1 : load_idx;
    sketch_a[idx] = item[31:0];
    sketch_b[idx] = item[63:32];
    if (idx + 1 < len) begin
      load_idx = idx + 1;
    end else begin
      load_idx = 0;
      expected_results.insert(expected_results.size(),
                              jaccard_of_pair(len, item[79:64], item[95:80]));
    end
  endfunction

  // Sends one element pair; the prediction is made when the transfer happens.
  task automatic send_elem(input logic [31:0] a, input logic [31:0] b,
                           input logic [15:0] row, input logic [15:0] col);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {col, row, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_load({col, row, b, a});
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // A partly loaded pair keeps its load index across a length change.
  task automatic write_length(input logic [11:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    length_reg = value;
  endtask

  // Sorted sketch with random holes, drawn from a small pool so matches happen.
  task automatic send_sorted_pair(input int unsigned len, input int unsigned pool,
                                  input int unsigned hole_pct);
    logic [15:0] row, col;
    int signed va, vb;
    row = 16'($urandom); col = 16'($urandom);
    va = -int'(pool); vb = -int'(pool);
    for (int unsigned i = 0; i < len; i++) begin
      va += $urandom_range(1, 3);
      vb += $urandom_range(1, 3);
      send_elem(($urandom_range(0, 99) < hole_pct) ? 32'd0 : va,
                ($urandom_range(0, 99) < hole_pct) ? 32'd0 : vb, row, col);
    end
  endtask

  task automatic send_noise_pair(input int unsigned len);
    logic [15:0] row, col;
    row = 16'($urandom); col = 16'($urandom);
    for (int unsigned i = 0; i < len; i++)
      send_elem($urandom, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, row, col);
  endtask

  task automatic test_directed_extremes();
    write_length(12'd4);
    send_elem(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000);
    send_elem(32'h8000_0000, 32'h8000_0000, 16'h0000, 16'hFFFF);
    send_elem(32'hFFFF_FFFF, 32'h0000_0001, 16'hA5A5, 16'h5A5A);
    send_elem(32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    // Both sketches empty: union is zero.
    for (int i = 0; i < 4; i++) send_elem(32'd0, 32'd0, 16'h1234, 16'h4321);
    // Identical sketches, one empty side, then a one-sided tail.
    for (int i = 0; i < 4; i++) send_elem(32'd5 + i, 32'd5 + i, 16'h1, 16'h2);
    for (int i = 0; i < 4; i++) send_elem(32'd0, $urandom, 16'h3, 16'h4);
    for (int i = 0; i < 4; i++) send_elem(-32'sd10 + i, 32'h7000_0000, 16'h5, 16'h6);
  endtask

  task automatic test_length_extremes();
    // A length of zero acts as one.
    write_length(12'd0);
    send_elem(32'd7, 32'd7, 16'hBEEF, 16'hCAFE);
    send_elem(32'd0, 32'd3, 16'h0001, 16'h0002);
    write_length(12'd1);
    send_elem(32'd9, 32'd8, 16'h0003, 16'h0004);
    // One long pair walks the pointers far past the short lengths.
    write_length(12'd200);
    send_sorted_pair(200, 150, 30);
  endtask

  task automatic test_length_lowered_mid_load();
    write_length(12'd8);
    for (int i = 0; i < 5; i++) send_elem($urandom, $urandom, 16'h10, 16'h20);
    write_length(12'd3);
    // The load index already passed the new length, so this completes the pair.
    send_elem(32'd1, 32'd1, 16'h30, 16'h40);
    for (int i = 0; i < 3; i++) send_elem(i + 1, i + 2, 16'h50, 16'h60);
  endtask

  task automatic test_random_pairs();
    int unsigned len;
    for (int p = 0; p < 90; p++) begin
      if (p % 30 == 0) write_length(12'($urandom_range(1, 16)));
      len = (length_reg == 0) ? 1 : length_reg;
      if ($urandom_range(0, 4) == 0) send_noise_pair(len);
      else send_sorted_pair(len, $urandom_range(4, 40), $urandom_range(0, 50));
    end
  endtask

  task automatic test_backpressure();
    write_length(12'd2);
    // The receiver holds off while several pairs are offered, so the block stalls.
    recv_hold = 400;
    for (int p = 0; p < 10; p++) send_sorted_pair(2, 6, 20);
    // Pause until every result is back, then resume.
    drain();
    for (int p = 0; p < 5; p++) send_sorted_pair(2, 6, 20);
  endtask

  task automatic test_no_gaps();
    send_gaps = 0;
    recv_gaps = 0;
    write_length(12'd6);
    for (int p = 0; p < 20; p++) send_sorted_pair(6, 12, 25);
  endtask

  // Receiver: random stall bursts and one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_burst    <= 0;
    end else if (recv_hold > 0) begin
      recv_hold     <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_burst > 0) begin
      recv_burst    <= recv_burst - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      recv_burst    <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row_id       = m_axis_tdata[15:0];
      got.col_id       = m_axis_tdata[31:16];
      got.passed       = m_axis_tdata[32];
      got.similarity   = m_axis_tdata[52:33];
      got.shared_count = m_axis_tdata[64:53];
      got.union_size   = m_axis_tdata[77:65];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.row_id != want.row_id) report_mismatch("row_id", got.row_id, want.row_id);
        if (got.col_id != want.col_id) report_mismatch("col_id", got.col_id, want.col_id);
        if (got.passed != want.passed) report_mismatch("passed", got.passed, want.passed);
        if (got.similarity != want.similarity)
          report_mismatch("similarity", got.similarity, want.similarity);
        if (got.shared_count != want.shared_count)
          report_mismatch("shared_count", got.shared_count, want.shared_count);
        if (got.union_size != want.union_size)
          report_mismatch("union_size", got.union_size, want.union_size);
        if (m_axis_tdata[79:78] != 2'b00) report_mismatch("pad", m_axis_tdata[79:78], 0);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    idle_cycles   = 0;
    recv_hold     = 0;
    send_gaps     = 1;
    recv_gaps     = 1;
    load_idx      = 0;
    length_reg    = 12'd2048;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 12'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_length_lowered_mid_load();
    test_random_pairs();
    test_backpressure();
    test_length_extremes();
    test_no_gaps();
    drain();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
